// ----- rtl/bsk_pkg.sv -----
// ----------------------------------------------------------------------------
// bsk_pkg - shared types and constants of the best-K store
// Command codes, configuration widths and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
package bsk_pkg;

  // Command field codes
  localparam logic CMD_INSERT    = 1'b0;
  localparam logic CMD_NEW_BATCH = 1'b1;

  // Keep-limit register
  localparam int unsigned LIMIT_BITS  = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  // Per-cell control, driven from the top level each cycle
  typedef struct packed {
    logic load;  // a request is being inserted this cycle
    logic live;  // the cell holds an entry that survives this insert
    logic tail;  // the cell is the first free slot after the survivors
  } cell_ctrl_t;

endpackage

// ----- rtl/bsk_req_if.sv -----
// ----------------------------------------------------------------------------
// bsk_req_if - request channel of the best-K store
// Valid/ready handshake carrying command, score and target tag.
// ----------------------------------------------------------------------------
interface bsk_req_if #(
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned TAG_BITS   = 16
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [SCORE_BITS-1:0] score_in;
  logic        [TAG_BITS-1:0]   target_in;

  modport source (output valid, command, score_in, target_in, input ready);
  modport sink   (input valid, command, score_in, target_in, output ready);
endinterface

// ----- rtl/bsk_res_if.sv -----
// ----------------------------------------------------------------------------
// bsk_res_if - result channel of the best-K store
// Valid/ready handshake carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface bsk_res_if #(
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned TAG_BITS   = 16,
  parameter int unsigned FILL_BITS  = 5
);
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic                         new_best;
  logic signed [SCORE_BITS-1:0] best_score;
  logic        [TAG_BITS-1:0]   best_target;
  logic        [FILL_BITS-1:0]  fill_count;

  modport source (output valid, accepted, new_best, best_score, best_target, fill_count,
                  input ready);
  modport sink   (input valid, accepted, new_best, best_score, best_target, fill_count,
                  output ready);
endinterface

// ----- rtl/bsk_cell.sv -----
// ----------------------------------------------------------------------------
// bsk_cell - one slot of the sorted insertion row
// Compare the broadcast score, shift in from the left neighbour or load it.
// ----------------------------------------------------------------------------
module bsk_cell #(
  parameter int unsigned SCORE_BITS = 32,
  parameter int unsigned TAG_BITS   = 16
) (
  input  logic                         clk,
  input  bsk_pkg::cell_ctrl_t          ctrl,
  input  logic signed [SCORE_BITS-1:0] new_score,
  input  logic        [TAG_BITS-1:0]   new_target,
  input  logic                         prev_ahead,
  input  logic signed [SCORE_BITS-1:0] prev_score,
  input  logic        [TAG_BITS-1:0]   prev_target,
  output logic                         ahead,
  output logic                         above,
  output logic signed [SCORE_BITS-1:0] score,
  output logic        [TAG_BITS-1:0]   target
);
  import bsk_pkg::*;

  // New score goes ahead of this entry only when strictly lower
  assign ahead = ctrl.live && (new_score < score);
  // Entry strictly better than the new score
  assign above = score < new_score;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (prev_ahead) begin
        score  <= prev_score;
        target <= prev_target;
      end else if (ahead || ctrl.tail) begin
        score  <= new_score;
        target <= new_target;
      end
    end
  end

endmodule

// ----- rtl/bounded_sorted_best_k_store.sv -----
// ----------------------------------------------------------------------------
// bounded_sorted_best_k_store - sorted store of the K lowest-scoring candidates
// A row of compare-and-shift cells keeps the entries in ascending score order.
// ----------------------------------------------------------------------------
// Result: an accepted request shows its result in the cycle after it is taken.
// Throughput: one request per cycle while results are taken; the row of cells
//   compares every entry against the broadcast score and all shift together.
// Reset: clears the fill count, the kept best (score and tag zero), the result
//   valid flag and sets keep_limit to 16. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_sorted_best_k_store #(
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned SCORE_BITS  = 32,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bsk_pkg::LIMIT_BITS-1:0] cfg_data,
  bsk_req_if.sink                      req,
  bsk_res_if.source                    res
);
  import bsk_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(STORE_DEPTH + 1);
  // Width wide enough for both the limit register and the fill count
  localparam int unsigned LW = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

  // Configuration and control state
  logic [LIMIT_BITS-1:0]        keep_limit;
  logic [CNT_BITS-1:0]          held;
  logic signed [SCORE_BITS-1:0] best_key;
  logic        [TAG_BITS-1:0]   best_tag;

  // Row signals
  cell_ctrl_t                   ctrl    [STORE_DEPTH];
  logic                         ahead   [STORE_DEPTH];
  logic                         above   [STORE_DEPTH];
  logic signed [SCORE_BITS-1:0] score   [STORE_DEPTH];
  logic        [TAG_BITS-1:0]   target  [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]       last_hit;

  logic                         take;
  logic [LW-1:0]                lim;
  logic [CNT_BITS-1:0]          held_eff;
  logic [CNT_BITS-1:0]          survivors;
  logic [CNT_BITS-1:0]          last_idx;
  logic                         full;
  logic                         reject;
  logic                         front;

  // Hold a request while the result register is occupied and not being taken
  assign req.ready = !res.valid || res.ready;
  assign take      = req.valid && req.ready;

  // Clamp the limit to the range one to STORE_DEPTH
  always_comb begin
    lim = LW'(keep_limit);
    if (lim == '0) begin
      lim = LW'(1);
    end
    if (lim > LW'(STORE_DEPTH)) begin
      lim = LW'(STORE_DEPTH);
    end
  end

  // A new batch empties the store before the insert
  assign held_eff  = (req.command == CMD_NEW_BATCH) ? '0 : held;
  assign full      = LW'(held_eff) >= lim;
  // When full, drop the last entry to make room
  assign survivors = full ? held_eff - CNT_BITS'(1) : held_eff;
  assign last_idx  = held_eff - CNT_BITS'(1);

  // Reject when full and the last entry is strictly better
  assign reject = full && (|last_hit);
  // Lands at the front when it beats the first survivor or there is none
  assign front  = (survivors == '0) || ahead[0];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_row
    assign ctrl[i].load = take && !reject;
    assign ctrl[i].live = CNT_BITS'(i) < survivors;
    assign ctrl[i].tail = CNT_BITS'(i) == survivors;
    assign last_hit[i]  = (CNT_BITS'(i) == last_idx) && above[i];

    if (i == 0) begin : g_head
      bsk_cell #(
        .SCORE_BITS (SCORE_BITS),
        .TAG_BITS   (TAG_BITS)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl[i]),
        .new_score   (req.score_in),
        .new_target  (req.target_in),
        .prev_ahead  (1'b0),
        .prev_score  (req.score_in),
        .prev_target (req.target_in),
        .ahead       (ahead[i]),
        .above       (above[i]),
        .score       (score[i]),
        .target      (target[i])
      );
    end else begin : g_body
      // Shift from the left neighbour when the new score lands ahead of it
      bsk_cell #(
        .SCORE_BITS (SCORE_BITS),
        .TAG_BITS   (TAG_BITS)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl[i]),
        .new_score   (req.score_in),
        .new_target  (req.target_in),
        .prev_ahead  (ahead[i-1]),
        .prev_score  (score[i-1]),
        .prev_target (target[i-1]),
        .ahead       (ahead[i]),
        .above       (above[i]),
        .score       (score[i]),
        .target      (target[i])
      );
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      keep_limit <= cfg_data;
    end
  end

  // Fill count and kept best
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      best_key <= '0;
      best_tag <= '0;
    end else if (take) begin
      if (reject) begin
        held <= held_eff;
      end else begin
        held <= survivors + CNT_BITS'(1);
        if (front) begin
          best_key <= req.score_in;
          best_tag <= req.target_in;
        end
      end
    end
  end

  // Result register: advance on a new request, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.accepted <= !reject;
      res.new_best <= !reject && front;
      if (!reject && front) begin
        res.best_score  <= req.score_in;
        res.best_target <= req.target_in;
        res.fill_count  <= survivors + CNT_BITS'(1);
      end else begin
        res.best_score  <= best_key;
        res.best_target <= best_tag;
        res.fill_count  <= reject ? held_eff : survivors + CNT_BITS'(1);
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench for the bounded sorted best-K store
// Drives insert and batch-start requests through the request channel, keeps a
// shadow copy of the sorted store and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bsk_pkg::*;

  typedef struct packed {
    logic               command;
    logic signed [31:0] score;
    logic        [15:0] target;
  } candidate_t;

  typedef struct packed {
    logic               accepted;
    logic               new_best;
    logic signed [31:0] best_score;
    logic        [15:0] best_target;
    logic        [4:0]  fill_count;
  } outcome_t;

  localparam int unsigned DEPTH = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_data = '0;

  // Local drivers of the channel inputs, known from time zero
  logic               drv_valid   = 1'b0;
  logic               drv_command = CMD_INSERT;
  logic signed [31:0] drv_score   = '0;
  logic        [15:0] drv_target  = '0;
  logic               sink_ready  = 1'b0;

  bsk_req_if #(.SCORE_BITS(32), .TAG_BITS(16)) req_ch ();
  bsk_res_if #(.SCORE_BITS(32), .TAG_BITS(16), .FILL_BITS(5)) res_ch ();

  assign req_ch.valid     = drv_valid;
  assign req_ch.command   = drv_command;
  assign req_ch.score_in  = drv_score;
  assign req_ch.target_in = drv_target;
  assign res_ch.ready     = sink_ready;

  bounded_sorted_best_k_store #(
    .STORE_DEPTH(DEPTH),
    .SCORE_BITS (32),
    .TAG_BITS   (16)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req_ch),
    .res     (res_ch)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and outcomes waiting to be seen
  candidate_t pending_q[$];
  outcome_t   outcome_q[$];

  // Shadow of the store, kept in step with accepted requests
  logic signed [31:0]     shadow_score [DEPTH];
  logic        [15:0]     shadow_tag   [DEPTH];
  int unsigned            shadow_fill  = 0;
  logic signed [31:0]     shadow_best_score = '0;
  logic        [15:0]     shadow_best_tag   = '0;
  logic [LIMIT_BITS-1:0]  shadow_limit      = LIMIT_RESET;

  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  logic        no_idle      = 1'b0;

  // Work out the outcome of one candidate and advance the shadow store.
  function automatic outcome_t insert_candidate(candidate_t c);
    outcome_t    o;
    int unsigned lim;
    int unsigned pos;
    lim = shadow_limit;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    o.accepted = 1'b0;
    o.new_best = 1'b0;
    if (c.command == CMD_NEW_BATCH) shadow_fill = 0;
    // Full and strictly worse than the last entry: reject, leave state alone
    if (!(shadow_fill >= lim && shadow_score[shadow_fill-1] < c.score)) begin
      // Drop the last entry to make room; a lowered limit keeps the fill
      if (shadow_fill >= lim) shadow_fill--;
      pos = shadow_fill;
      // Shift worse entries up; equal scores stay ahead of the newcomer
      while (pos > 0 && c.score < shadow_score[pos-1]) begin
        shadow_score[pos] = shadow_score[pos-1];
        shadow_tag[pos]   = shadow_tag[pos-1];
        pos--;
      end
      shadow_score[pos] = c.score;
      shadow_tag[pos]   = c.target;
      shadow_fill++;
      o.accepted = 1'b1;
      if (pos == 0) begin
        o.new_best        = 1'b1;
        shadow_best_score = c.score;
        shadow_best_tag   = c.target;
      end
    end
    o.best_score  = shadow_best_score;
    o.best_target = shadow_best_tag;
    o.fill_count  = shadow_fill[4:0];
    return o;
  endfunction

  // Driver: predict on acceptance, then hold, advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_ch.ready)
        outcome_q.insert(outcome_q.size(),
                         insert_candidate('{drv_command, drv_score, drv_target}));
      if (!drv_valid || req_ch.ready) begin
        if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 20)) begin
          drv_valid   <= 1'b1;
          drv_command <= pending_q[0].command;
          drv_score   <= pending_q[0].score;
          drv_target  <= pending_q[0].target;
          void'(pending_q.pop_front());
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is under way
  // so that the store backs up and stalls its request side.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      sink_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && results_seen >= 600) begin
      sink_ready <= 1'b0;
      hold_left  <= 150;
      hold_done  <= 1'b1;
    end else begin
      sink_ready <= no_idle || ($urandom_range(99) >= 20);
    end
  end

  // Monitor: compare each taken result with the oldest outcome waiting.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (res_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, res_ch.accepted);
          error_count++;
        end
        if (res_ch.new_best !== want.new_best) begin
          $error("new_best: expected %0d, got %0d", want.new_best, res_ch.new_best);
          error_count++;
        end
        if (res_ch.best_score !== want.best_score) begin
          $error("best_score: expected %0d, got %0d", want.best_score, res_ch.best_score);
          error_count++;
        end
        if (res_ch.best_target !== want.best_target) begin
          $error("best_target: expected %0h, got %0h", want.best_target, res_ch.best_target);
          error_count++;
        end
        if (res_ch.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, res_ch.fill_count);
          error_count++;
        end
      end
    end
  end

  task automatic queue_item(logic cmd, logic signed [31:0] score, logic [15:0] tag);
    candidate_t c;
    c = '{cmd, score, tag};
    pending_q.insert(pending_q.size(), c);
  endtask

  // Hold until every request has gone in and every result has come out.
  task automatic wait_idle();
    while (pending_q.size() != 0 || drv_valid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_BITS-1:0] value);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_data     <= value;
    shadow_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random batch: mostly inserts with an occasional batch start; scores mix
  // a narrow band (many ties), the full range and the extremes.
  task automatic queue_random(int unsigned count, int unsigned batch_odds);
    logic               cmd;
    logic signed [31:0] score;
    int unsigned        pick;
    for (int unsigned i = 0; i < count; i++) begin
      cmd  = ($urandom_range(batch_odds - 1) == 0) ? CMD_NEW_BATCH : CMD_INSERT;
      pick = $urandom_range(9);
      if (pick < 4) begin
        score = $signed($urandom_range(16)) - 8;
      end else if (pick < 8) begin
        score = $urandom;
      end else begin
        case ($urandom_range(3))
          0: score = 32'sh7FFF_FFFF;
          1: score = 32'sh8000_0000;
          2: score = 32'sd0;
          default: score = -32'sd1;
        endcase
      end
      queue_item(cmd, score, 16'($urandom_range(65535)));
    end
  endtask

  initial begin
    logic [LIMIT_BITS-1:0] phase_limit [8];
    phase_limit = '{5'd16, 5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limit: extremes of score and tag, ties, then a fresh batch
    queue_item(CMD_NEW_BATCH, 32'sh7FFF_FFFF, 16'h0000);
    queue_item(CMD_INSERT,    32'sh8000_0000, 16'hFFFF);
    queue_item(CMD_INSERT,    32'sd0,         16'h1234);
    queue_item(CMD_INSERT,    32'sd0,         16'h5678);
    queue_item(CMD_INSERT,    -32'sd1,        16'hA5A5);
    queue_item(CMD_INSERT,    32'sh7FFF_FFFF, 16'h5A5A);
    queue_item(CMD_NEW_BATCH, 32'sd5,         16'hAAAA);
    wait_idle();

    // Limit one: worse is rejected, equal to the last entry is taken
    write_limit(5'd1);
    queue_item(CMD_INSERT, 32'sd10,        16'h0001);
    queue_item(CMD_INSERT, 32'sd5,         16'h0002);
    queue_item(CMD_INSERT, 32'sd4,         16'h0003);
    queue_item(CMD_INSERT, 32'sh7FFF_FFFF, 16'h0004);
    wait_idle();

    // Limit zero behaves as one
    write_limit(5'd0);
    queue_item(CMD_INSERT, 32'sd3, 16'h0011);
    queue_item(CMD_INSERT, 32'sd3, 16'h0012);
    queue_item(CMD_INSERT, 32'sd9, 16'h0013);
    wait_idle();

    // Limit above the depth clamps to the depth
    write_limit(5'd31);
    queue_item(CMD_INSERT,    -32'sd7,        16'h0021);
    queue_item(CMD_INSERT,    32'sd2,         16'h0022);
    queue_item(CMD_NEW_BATCH, 32'sh8000_0000, 16'h0023);
    queue_item(CMD_INSERT,    32'sh8000_0000, 16'h0024);
    wait_idle();

    // Random phases; no batch start on entry, so a lowered limit meets a
    // fuller store. One phase runs with no idling on either side.
    for (int p = 0; p < 8; p++) begin
      if (p == 6) write_limit(5'($urandom_range(31)));
      else        write_limit(phase_limit[p]);
      no_idle = (p == 2);
      queue_random(235, (p % 2 == 0) ? 40 : 12);
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
